@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the node inertia force block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define NIF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("node inertia force check failed");

// next-cycle implication, sampled on clock, off during reset
`define NIF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("node inertia force check failed");

`endif

@@ hw/rtl/nif_pkg.sv @@
// ----------------------------------------------------------------------------
// nif_pkg
// Shared types, constants and the power table generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nif_pkg;

   localparam int TBL_BITS  = 16;
   localparam int DATA_W    = 32;
   localparam int UDATA_W   = 31;
   localparam int OUT_W     = 48;
   localparam int STIFF_W   = 47;
   localparam int CSR_IDX_W = 2;

   localparam logic [UDATA_W-1:0] FLUID_DENSITY_RESET = 31'd67108864;
   localparam logic [UDATA_W-1:0] INV_STEP_SQ_RESET   = 31'd65536;
   localparam logic               STIFF_ENABLE_RESET  = 1'b1;

   localparam logic signed [OUT_W-1:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [OUT_W-1:0] SAT_NEG = 48'sh8000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLUID_DENSITY = 2'd0,
      CSR_INV_STEP_SQ   = 2'd1,
      CSR_STIFF_ENABLE  = 2'd2
   } csr_index_type;

   // floor(2^16 * (idx/top)^0.4), exact integer search
   function automatic logic [TBL_BITS:0] pow_entry(input int unsigned idx,
                                                   input int unsigned top);
      logic [127:0] rhs;
      logic [127:0] lhs;
      logic [127:0] y;
      logic [127:0] lo;
      logic [127:0] hi;
      rhs = (128'(idx) * 128'(idx)) << 80;
      lo  = '0;
      hi  = 128'd65536;
      for (int k = 0; k < 18; k++) begin
         if (lo < hi) begin
            y   = (lo + hi + 128'd1) >> 1;
            lhs = y * y * y * y * y * 128'(top) * 128'(top);
            if (lhs <= rhs) begin
               lo = y;
            end else begin
               hi = y - 128'd1;
            end
         end
      end
      return lo[TBL_BITS:0];
   endfunction

endpackage

@@ hw/rtl/nif_delay.sv @@
// ----------------------------------------------------------------------------
// nif_delay
// Enabled shift line that aligns a word with the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nif_delay #(
   parameter int W = 32,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         enable,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] d_out
);

   if (D == 0) begin : g_none
      assign d_out = d_in;
   end else begin : g_line
      logic [W-1:0] line_ff [D];

      always_ff @(posedge clock) begin
         if (enable) begin
            line_ff[0] <= d_in;
            for (int i = 1; i < D; i++) begin
               line_ff[i] <= line_ff[i-1];
            end
         end
      end

      assign d_out = line_ff[D-1];
   end

endmodule

@@ hw/rtl/nif_qmul.sv @@
// ----------------------------------------------------------------------------
// nif_qmul
// Four-stage signed fixed-point multiply: magnitude, split partial
// products, sum with truncation and 48-bit saturation, sign restore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nif_qmul #(
   parameter int AW   = 48,
   parameter int BW   = 33,
   parameter int FRAC = 16
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [47:0]   p
);

   localparam int L  = (AW + 1) / 2;
   localparam int HW = AW - L;
   localparam int PW = AW + BW;

   logic [AW-1:0]   am_in, am_ff;
   logic [BW-1:0]   bm_in, bm_ff;
   logic            neg_in, neg1_ff, neg2_ff, neg3_ff;
   logic [L+BW-1:0] pl_in, pl_ff;
   logic [HW+BW-1:0] ph_in, ph_ff;
   logic [PW-1:0]   full;
   logic [127:0]    shifted;
   logic [47:0]     mag_in, mag_ff;
   logic [47:0]     p_in, p_ff;

   always_comb begin
      am_in  = a[AW-1] ? AW'(-a) : AW'(a);
      bm_in  = b[BW-1] ? BW'(-b) : BW'(b);
      neg_in = a[AW-1] ^ b[BW-1];
      pl_in  = (L+BW)'(am_ff[L-1:0]) * (L+BW)'(bm_ff);
      ph_in  = (HW+BW)'(am_ff[AW-1:L]) * (HW+BW)'(bm_ff);
      full   = (PW'(ph_ff) << L) + PW'(pl_ff);
      shifted = 128'(full) >> FRAC;
      if (neg2_ff) begin
         mag_in = (shifted > 128'h8000_0000_0000) ? 48'h8000_0000_0000 : shifted[47:0];
      end else begin
         mag_in = (shifted > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : shifted[47:0];
      end
      p_in = neg3_ff ? (48'd0 - mag_ff) : mag_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         am_ff   <= am_in;
         bm_ff   <= bm_in;
         neg1_ff <= neg_in;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         neg2_ff <= neg1_ff;
         mag_ff  <= mag_in;
         neg3_ff <= neg2_ff;
         p_ff    <= p_in;
      end
   end

   assign p = $signed(p_ff);

endmodule

@@ hw/rtl/nif_div.sv @@
// ----------------------------------------------------------------------------
// nif_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nif_div #(
   parameter int DW = 32,
   parameter int QB = 10
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [DW+QB-1:0] num,
   input  logic [DW-1:0]    den,
   output logic [QB-1:0]    quot
);

   localparam int NW = DW + QB;

   logic [NW-1:0] rem_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [NW-1:0] rem_prev [QB];
   logic [DW-1:0] den_prev [QB];
   logic [QB-1:0] q_prev   [QB];
   logic [NW-1:0] den_sh   [QB];
   logic [NW-1:0] rem_in   [QB];
   logic [QB-1:0] q_in     [QB];

   always_comb begin
      for (int s = 0; s < QB; s++) begin
         if (s == 0) begin
            rem_prev[s] = num;
            den_prev[s] = den;
            q_prev[s]   = '0;
         end else begin
            rem_prev[s] = rem_ff[s-1];
            den_prev[s] = den_ff[s-1];
            q_prev[s]   = q_ff[s-1];
         end
         den_sh[s] = NW'(den_prev[s]) << (QB - 1 - s);
         q_in[s]   = q_prev[s];
         if (rem_prev[s] >= den_sh[s]) begin
            q_in[s][QB-1-s] = 1'b1;
            rem_in[s]       = rem_prev[s] - den_sh[s];
         end else begin
            rem_in[s]       = rem_prev[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < QB; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_prev[s];
            q_ff[s]   <= q_in[s];
         end
      end
   end

   assign quot = q_ff[QB-1];

endmodule

@@ hw/rtl/node_inertia_force.sv @@
// ----------------------------------------------------------------------------
// node_inertia_force
// Inertia force and diagonal stiffness increments for one node axis.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  node, water, height, sizes, accels
//   rsp      out        rsp_valid/rsp_stall  force, stiffness, flags
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One word per cycle is taken while req_stall is low. A result's delay is set by
// the bit-per-stage index divider feeding the power table and the four-stage
// multiplies after it.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline, and req_stall rises with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module node_inertia_force #(
   parameter int FRAC_BITS      = 16,
   parameter int POW_TABLE_SIZE = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_node_level,
   input  logic signed [31:0]  req_water_level,
   input  logic signed [31:0]  req_node_height,
   input  logic [30:0]         req_length_x,
   input  logic [30:0]         req_length_y,
   input  logic [30:0]         req_added_mass,
   input  logic [30:0]         req_node_mass,
   input  logic signed [31:0]  req_fluid_accel,
   input  logic signed [31:0]  req_node_accel,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [47:0]  rsp_force_increment,
   output logic [46:0]         rsp_stiffness_increment,
   output logic                rsp_stiffness_valid,
   output logic                rsp_last_out,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [30:0]         csr_write_data
);

   localparam int QB   = $clog2(POW_TABLE_SIZE);
   localparam int TI   = QB + 3;
   localparam int NST  = QB + 12;
   localparam int IMW  = FRAC_BITS + 1;
   localparam int NW   = 32 + QB;
   localparam int TOP  = POW_TABLE_SIZE - 1;
   localparam logic [IMW-1:0] IMMER_ONE = IMW'(1) << FRAC_BITS;

   logic [30:0] fluid_density_ff;
   logic [30:0] inv_step_sq_ff;
   logic        stiffness_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fluid_density_ff    <= nif_pkg::FLUID_DENSITY_RESET;
         inv_step_sq_ff      <= nif_pkg::INV_STEP_SQ_RESET;
         stiffness_enable_ff <= nif_pkg::STIFF_ENABLE_RESET;
      end else if (csr_write_enable) begin
         case (nif_pkg::csr_index_type'(csr_index))
            nif_pkg::CSR_FLUID_DENSITY: fluid_density_ff    <= csr_write_data;
            nif_pkg::CSR_INV_STEP_SQ:   inv_step_sq_ff      <= csr_write_data;
            nif_pkg::CSR_STIFF_ENABLE:  stiffness_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic v_ff [NST+1];

   assign adv       = !v_ff[NST] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NST; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i <= NST; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage 0: capture word
   logic signed [31:0] wf_ff, wl_ff, h_ff, ga_ff, gb_ff;
   logic [30:0]        lx_ff, ly_ff, ma_ff, m_ff;
   logic               last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         wf_ff   <= req_node_level;
         wl_ff   <= req_water_level;
         h_ff    <= req_node_height;
         lx_ff   <= req_length_x;
         ly_ff   <= req_length_y;
         ma_ff   <= req_added_mass;
         m_ff    <= req_node_mass;
         ga_ff   <= req_fluid_accel;
         gb_ff   <= req_node_accel;
         last_ff <= req_last_item;
      end
   end

   // stage 1: immersed depth
   logic signed [33:0] top_lvl, wf34, wl34, h34;
   logic signed [33:0] depth_w;
   logic [31:0]        depth_in, depth_ff, habs_in, habs_ff;
   logic               hzero_ff;
   logic signed [32:0] gdiff_in, gdiff_ff;

   always_comb begin
      wf34    = 34'(wf_ff);
      wl34    = 34'(wl_ff);
      h34     = 34'(h_ff);
      top_lvl = wf34 + h34;
      depth_w = '0;
      if (!h_ff[31]) begin
         if (top_lvl < wl34) begin
            depth_w = h34;
         end else if (wf34 <= wl34) begin
            depth_w = wl34 - wf34;
         end
      end else begin
         if (wf34 < wl34) begin
            depth_w = -h34;
         end else if (top_lvl <= wl34) begin
            depth_w = wl34 - top_lvl;
         end
      end
      depth_in = depth_w[31:0];
      habs_in  = h_ff[31] ? 32'(-h34) : 32'(h34);
      gdiff_in = 33'(ga_ff) - 33'(gb_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         depth_ff <= depth_in;
         habs_ff  <= habs_in;
         hzero_ff <= (h_ff == '0);
         gdiff_ff <= gdiff_in;
      end
   end

   // stage 2: scaled numerator for the table index
   logic [NW-1:0] num_in, num_ff;
   logic [31:0]   habs2_ff;
   logic [QB-1:0] quot, idx;

   assign num_in = NW'(depth_ff) * NW'(TOP);

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff   <= num_in;
         habs2_ff <= habs_ff;
      end
   end

   nif_div #(.DW(32), .QB(QB)) u_div (
      .clock  (clock),
      .enable (adv),
      .num    (num_ff),
      .den    (habs2_ff),
      .quot   (quot)
   );

   assign idx = (quot > QB'(TOP)) ? QB'(TOP) : quot;

   logic [nif_pkg::TBL_BITS:0] pow_rom [POW_TABLE_SIZE];
   logic [nif_pkg::TBL_BITS:0] entry_ff;

   for (genvar gr = 0; gr < POW_TABLE_SIZE; gr++) begin : g_rom
      localparam logic [nif_pkg::TBL_BITS:0] ENTRY = nif_pkg::pow_entry(gr, TOP);
      assign pow_rom[gr] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff <= pow_rom[idx];
      end
   end

   logic          hzero_d;
   logic [40:0]   imm_wide;
   logic [IMW-1:0] immer;

   nif_delay #(.W(1), .D(TI-1)) u_dl_hzero (
      .clock(clock), .enable(adv), .d_in(hzero_ff), .d_out(hzero_d)
   );

   assign imm_wide = (41'(entry_ff) << 24) >> (40 - FRAC_BITS);
   assign immer    = hzero_d ? IMMER_ONE : imm_wide[IMW-1:0];

   // volume branch
   logic [30:0]        lx_d, ly_d, ma_d, m_d;
   logic signed [31:0] ga_d;
   logic signed [32:0] gdiff_d;
   logic signed [47:0] vol1, vol, dv, t2, t2_d, t3, t3_d, mi, t1, stiff;

   nif_delay #(.W(31), .D(1)) u_dl_lx (
      .clock(clock), .enable(adv), .d_in(lx_ff), .d_out(lx_d)
   );
   nif_delay #(.W(31), .D(5)) u_dl_ly (
      .clock(clock), .enable(adv), .d_in(ly_ff), .d_out(ly_d)
   );
   nif_delay #(.W(32), .D(13)) u_dl_ga (
      .clock(clock), .enable(adv), .d_in(ga_ff), .d_out(ga_d)
   );

   nif_qmul #(.AW(33), .BW(32), .FRAC(FRAC_BITS)) u_mul_vol1 (
      .clock(clock), .enable(adv),
      .a($signed({1'b0, depth_ff})), .b($signed({1'b0, lx_d})), .p(vol1)
   );
   nif_qmul #(.AW(48), .BW(32), .FRAC(FRAC_BITS)) u_mul_vol (
      .clock(clock), .enable(adv), .a(vol1), .b($signed({1'b0, ly_d})), .p(vol)
   );
   nif_qmul #(.AW(48), .BW(32), .FRAC(FRAC_BITS)) u_mul_dv (
      .clock(clock), .enable(adv), .a(vol), .b($signed({1'b0, fluid_density_ff})),
      .p(dv)
   );
   nif_qmul #(.AW(48), .BW(32), .FRAC(FRAC_BITS)) u_mul_t2 (
      .clock(clock), .enable(adv), .a(dv), .b(ga_d), .p(t2)
   );
   nif_delay #(.W(48), .D(TI-9)) u_dl_t2 (
      .clock(clock), .enable(adv), .d_in(t2), .d_out(t2_d)
   );

   // structural mass term
   nif_qmul #(.AW(32), .BW(32), .FRAC(FRAC_BITS)) u_mul_t3 (
      .clock(clock), .enable(adv), .a($signed({1'b0, m_ff})), .b(gb_ff), .p(t3)
   );
   nif_delay #(.W(48), .D(TI+4)) u_dl_t3 (
      .clock(clock), .enable(adv), .d_in(t3), .d_out(t3_d)
   );

   // added mass branch
   nif_delay #(.W(31), .D(TI)) u_dl_ma (
      .clock(clock), .enable(adv), .d_in(ma_ff), .d_out(ma_d)
   );
   nif_delay #(.W(31), .D(TI+4)) u_dl_m (
      .clock(clock), .enable(adv), .d_in(m_ff), .d_out(m_d)
   );
   nif_delay #(.W(33), .D(TI+3)) u_dl_gdiff (
      .clock(clock), .enable(adv), .d_in(gdiff_ff), .d_out(gdiff_d)
   );

   nif_qmul #(.AW(32), .BW(IMW+1), .FRAC(FRAC_BITS)) u_mul_mi (
      .clock(clock), .enable(adv),
      .a($signed({1'b0, ma_d})), .b($signed({1'b0, immer})), .p(mi)
   );
   nif_qmul #(.AW(48), .BW(33), .FRAC(FRAC_BITS)) u_mul_t1 (
      .clock(clock), .enable(adv), .a(mi), .b(gdiff_d), .p(t1)
   );

   logic signed [48:0] s_in, s_ff;

   assign s_in = 49'(mi) + $signed({18'd0, m_d});

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= s_in;
      end
   end

   nif_qmul #(.AW(49), .BW(32), .FRAC(FRAC_BITS)) u_mul_stiff (
      .clock(clock), .enable(adv), .a(s_ff), .b($signed({1'b0, inv_step_sq_ff})),
      .p(stiff)
   );

   // force sum and output register
   logic signed [49:0] fsum;
   logic signed [47:0] force_in, force_ff;
   logic               last_d;

   always_comb begin
      fsum = 50'(t1) + 50'(t2_d) - 50'(t3_d);
      if (fsum > 50'(nif_pkg::SAT_POS)) begin
         force_in = nif_pkg::SAT_POS;
      end else if (fsum < 50'(nif_pkg::SAT_NEG)) begin
         force_in = nif_pkg::SAT_NEG;
      end else begin
         force_in = fsum[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         force_ff <= force_in;
      end
   end

   nif_delay #(.W(1), .D(NST)) u_dl_last (
      .clock(clock), .enable(adv), .d_in(last_ff), .d_out(last_d)
   );

   assign rsp_valid               = v_ff[NST];
   assign rsp_force_increment     = force_ff;
   assign rsp_stiffness_increment = stiffness_enable_ff ? stiff[46:0] : '0;
   assign rsp_stiffness_valid     = stiffness_enable_ff;
   assign rsp_last_out            = last_d;

   `NIF_ASSERT_IMPL(a_immer_range, v_ff[TI], immer <= IMMER_ONE)
   `NIF_ASSERT_IMPL(a_stiff_off, rsp_valid && !stiffness_enable_ff, rsp_stiffness_increment == '0)
   `NIF_ASSERT_IMPL(a_hold_input, rsp_valid && rsp_stall, req_stall)
   `NIF_ASSERT_NEXT(a_last_stage, v_ff[NST-1] && !req_stall, rsp_valid)

endmodule
